/* src/insertion_sorter_descending_macros.svh */
// Assertion macros used by the insertion sorter datapath.
`ifndef INSERTION_SORTER_DESCENDING_MACROS_SVH
`define INSERTION_SORTER_DESCENDING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ISD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/isd_pkg.sv */
// Types and constants for the descending insertion sorter.
`timescale 1ns / 1ps

package isd_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_item;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_result;
        logic               overflow;
    } out_req_t;

    // Controller to datapath
    typedef struct packed {
        logic insert;
        logic load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fill_one;
    } status_t;

endpackage

/* src/isd_dp.sv */
// Datapath: systolic insertion row, fill count, drop flag, output register.
`timescale 1ns / 1ps
`include "insertion_sorter_descending_macros.svh"

module isd_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  isd_pkg::cmd_t     cmd,
    input  isd_pkg::in_req_t  in_data,
    output isd_pkg::status_t  status,
    output isd_pkg::out_req_t out_data
);

    logic signed [31:0] row_reg  [isd_pkg::DEPTH];
    logic signed [31:0] row_next [isd_pkg::DEPTH];
    logic signed [31:0] row_up   [isd_pkg::DEPTH];
    logic signed [31:0] row_down [isd_pkg::DEPTH];
    logic [isd_pkg::DEPTH-1:0] ge;
    logic [isd_pkg::DEPTH-1:0] ge_prev;
    logic [isd_pkg::CNT_W-1:0] fill_reg, fill_next;
    logic dropped_reg, dropped_next;
    logic full;
    isd_pkg::out_req_t out_reg, out_next;

    assign full = (fill_reg == isd_pkg::FULL_CNT);

    // Neighbor taps for the shift on insert and on drain
    assign row_up[0] = in_data.value;
    assign row_down[isd_pkg::DEPTH-1] = row_reg[isd_pkg::DEPTH-1];
    for (genvar g = 1; g < isd_pkg::DEPTH; g++) begin : g_taps
        assign row_up[g]     = row_reg[g-1];
        assign row_down[g-1] = row_reg[g];
    end

    // Each cell: holds a valid entry >= incoming value
    always_comb
    begin
        for (int i = 0; i < isd_pkg::DEPTH; i++)
        begin
            ge[i] = (fill_reg > isd_pkg::CNT_W'(i)) && (row_reg[i] >= in_data.value);
        end
    end
    assign ge_prev = {ge[isd_pkg::DEPTH-2:0], 1'b1};

    // Row update: keep, take new value, or shift
    always_comb
    begin
        for (int i = 0; i < isd_pkg::DEPTH; i++)
        begin
            row_next[i] = row_reg[i];
            if (cmd.insert && !full)
            begin
                if (!ge[i])
                begin
                    row_next[i] = ge_prev[i] ? in_data.value : row_up[i];
                end
            end
            else if (cmd.load)
            begin
                row_next[i] = row_down[i];
            end
        end
    end

    // Count, drop flag and output register
    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        out_next     = out_reg;
        if (cmd.insert)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + isd_pkg::ONE_CNT;
            end
        end
        else if (cmd.load)
        begin
            out_next.sorted_value = row_reg[0];
            out_next.last_result  = (fill_reg == isd_pkg::ONE_CNT);
            out_next.overflow     = dropped_reg;
            fill_next             = fill_reg - isd_pkg::ONE_CNT;
            if (fill_reg == isd_pkg::ONE_CNT)
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        out_reg <= out_next;
    end

    assign status.fill_one = (fill_reg == isd_pkg::ONE_CNT);
    assign out_data        = out_reg;

    `ISD_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= isd_pkg::FULL_CNT, "fill count above depth")
    `ISD_ASSERT_IMP(a_load_nonempty, clk, rst_n, cmd.load, fill_reg != '0, "drain from empty row")
    `ISD_ASSERT_IMP(a_cmd_excl, clk, rst_n, cmd.insert, !cmd.load, "insert and drain together")
    `ISD_ASSERT_NXT(a_drop_sets, clk, rst_n, cmd.insert && full, dropped_reg, "drop not flagged")

endmodule

/* src/isd_ctrl.sv */
// Controller: fill/drain state machine and output valid.
`timescale 1ns / 1ps

module isd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  isd_pkg::status_t status,
    output isd_pkg::cmd_t    cmd
);

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == S_FILL);
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.insert     = 1'b0;
        cmd.load       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_FILL:
            begin
                if (in_valid)
                begin
                    cmd.insert = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.fill_one)
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/insertion_sorter_descending.sv */
// Inserts one value per cycle while filling; after the request marked last, the sorted list drains out.
// After the request marked last, the controller enters the drain state and then loads the
//   first result into the output register, once the output register is free.
// Throughput: one value per cycle while filling; a batch of N stored values drains one result
//   at a time while out_ready is high, during which no request is taken.
// Reset (rst_n, async, active low) clears fill count, drop flag and control; row is kept.
`timescale 1ns / 1ps

module insertion_sorter_descending (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  isd_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output isd_pkg::out_req_t out_data
);

    isd_pkg::cmd_t    cmd;
    isd_pkg::status_t status;

    isd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_item),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    isd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .status   (status),
        .out_data (out_data)
    );

endmodule

/* tb/sv/tb.sv */
// Testbench for the descending insertion sorter: directed table, random batches, self-checking.
`timescale 1ns / 1ps

module tb;
    import isd_pkg::*;

    localparam int GAP_MAX        = 14;
    localparam int RAND_ITEMS     = 260;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int DIR_ROWS       = 22;

    localparam logic signed [31:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] V_NEG = 32'shFFFF_FFFF;

    // Value styles for random batches
    typedef enum int { VAL_WIDE, VAL_NARROW, VAL_EDGE } val_style_t;

    // One directed row; res is only meaningful when has_res is set
    typedef struct packed {
        in_req_t  req;
        logic     has_res;
        out_req_t res;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_req_t  in_data;
    logic     out_valid;
    logic     out_ready;
    out_req_t out_data;

    // Sorter state as the checker sees it
    logic signed [31:0] ranked [DEPTH];
    int                 ranked_cnt;
    logic               batch_dropped;

    out_req_t flush_q [$];
    out_req_t pending_sorted [$];

    int mismatches;
    int items_sent;
    bit tx_gaps;
    bit rx_gaps;
    bit rx_hold_req;

    // Single-value batches from an empty store are typed in; the long batch
    // fills the store, then drops one plain request and a dropped last one.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{V_MAX, 1'b1}, 1'b1, '{V_MAX, 1'b1, 1'b0}},
        '{'{V_MIN, 1'b1}, 1'b1, '{V_MIN, 1'b1, 1'b0}},
        '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{'{V_NEG, 1'b1}, 1'b1, '{V_NEG, 1'b1, 1'b0}},
        '{'{V_MAX, 1'b0}, 1'b0, '0},
        '{'{V_MIN, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 1'b0}, 1'b0, '0},
        '{'{V_NEG, 1'b0}, 1'b0, '0},
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{-32'sd5, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd2, 1'b0}, 1'b0, '0},
        '{'{-32'sd2, 1'b0}, 1'b0, '0},
        '{'{32'sd100, 1'b0}, 1'b0, '0},
        '{'{-32'sd100, 1'b0}, 1'b0, '0},
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{V_MAX, 1'b0}, 1'b0, '0},
        '{'{V_MIN, 1'b0}, 1'b0, '0},
        '{'{32'sd3, 1'b0}, 1'b0, '0},
        '{'{32'sd9, 1'b0}, 1'b0, '0},
        '{'{32'sd6, 1'b1}, 1'b0, '0}
    };

    insertion_sorter_descending i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Insert one request; on the batch end, collect the whole list in flush_q
    function automatic void insert_request(input in_req_t req);
        int       pos;
        out_req_t res;
        flush_q.delete();
        if (ranked_cnt >= DEPTH)
        begin
            batch_dropped = 1'b1;
        end
        else
        begin
            // walk past every entry >= the new value, shifting smaller ones down
            pos = ranked_cnt;
            while (pos > 0 && ranked[pos-1] < req.value)
            begin
                ranked[pos] = ranked[pos-1];
                pos--;
            end
            ranked[pos] = req.value;
            ranked_cnt++;
        end
        if (req.last_item)
        begin
            for (int k = 0; k < ranked_cnt; k++)
            begin
                res.sorted_value = ranked[k];
                res.last_result  = (k == ranked_cnt - 1);
                res.overflow     = batch_dropped;
                flush_q.push_back(res);
            end
            ranked_cnt    = 0;
            batch_dropped = 1'b0;
        end
    endfunction

    function automatic logic signed [31:0] pick_value(input val_style_t style);
        int sel;
        int narrow;
        case (style)
            VAL_NARROW:
            begin
                narrow = $urandom_range(0, 6);
                return narrow - 3;
            end
            VAL_EDGE:
            begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: return V_MAX;
                    1: return V_MIN;
                    2: return 32'sd0;
                    3: return V_NEG;
                    4: return 32'sd1;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and hold it until taken, then record its results
    task automatic send_request(input in_req_t req, input logic has_res, input out_req_t res);
        int gap;
        gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        insert_request(req);
        if (has_res)
            pending_sorted.push_back(res);
        else
            foreach (flush_q[i]) pending_sorted.push_back(flush_q[i]);
        items_sent++;
    endtask

    // Sender stops until every expected result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0) @(posedge clk);
    endtask

    // Request side
    initial
    begin
        int         len;
        int         shape;
        int         batch_no;
        val_style_t style;
        in_req_t    req;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        ranked_cnt    = 0;
        batch_dropped = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        rx_hold_req   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].has_res, dir_rows[i].res);

        // random batches
        items_sent = 0;
        batch_no   = 0;
        while (items_sent < RAND_ITEMS)
        begin
            shape = $urandom_range(0, 9);
            if (shape == 0)
                len = $urandom_range(DEPTH + 1, DEPTH + 8);
            else if (shape == 1)
                len = DEPTH;
            else if (shape == 2)
                len = 1;
            else
                len = $urandom_range(2, DEPTH - 1);
            style   = val_style_t'($urandom_range(0, 2));
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);

            // once: receiver stalls long while requests keep coming
            if (batch_no == 2)
            begin
                wait_drained();
                tx_gaps     = 1'b0;
                rx_hold_req = 1'b1;
                len         = 6;
            end
            // the batch after the hold must be offered into the stalled block
            else if (batch_no != 3 && $urandom_range(0, 7) == 0)
            begin
                wait_drained();
            end

            for (int k = 0; k < len; k++)
            begin
                req.value     = pick_value(style);
                req.last_item = (k == len - 1);
                send_request(req, 1'b0, '0);
            end
            batch_no++;
        end

        in_valid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            stall = rx_gaps ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid && !rx_hold_req);
        end
    end

    // Compare each taken result with the oldest expected one
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_sorted.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", out_data.sorted_value);
                mismatches++;
            end
            else
            begin
                want = pending_sorted.pop_front();
                if (out_data.sorted_value !== want.sorted_value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, out_data.sorted_value);
                    mismatches++;
                end
                if (out_data.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0b, got %0b",
                           want.last_result, out_data.last_result);
                    mismatches++;
                end
                if (out_data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, out_data.overflow);
                    mismatches++;
                end
            end
        end
    end

endmodule

/* insertion_sorter_descending.f */
+incdir+src
src/isd_pkg.sv
src/isd_dp.sv
src/isd_ctrl.sv
src/insertion_sorter_descending.sv
tb/sv/tb.sv
